/* src/led_pkg.sv */
// Package: LED cipher constants, types and round function.
`timescale 1ns / 1ps
`default_nettype none
package led_pkg;

  localparam int ROUNDS_MAX  = 48;
  localparam int ROUNDS_MIN  = 32;
  localparam int RK_ROWS     = 13;
  localparam int RK_NIBBLES  = RK_ROWS * 16;
  localparam int CNT_W       = $clog2(RK_NIBBLES);
  localparam int ROW_W       = $clog2(RK_ROWS);

  localparam logic [1:0] CFG_KEY_SIZE = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [1:0] CFG_KEY_LOW  = 2'd2;

  localparam logic [7:0] KEY_SIZE_RST = 8'd128;
  localparam logic [7:0] KEY_SIZE_SHORT = 8'd64;
  localparam logic [5:0] KEY_NIB_MAX = 6'd32;

  localparam logic [3:0] LED_SBOX [0:15] = '{
    4'd12, 4'd5, 4'd6, 4'd11, 4'd9, 4'd0, 4'd10, 4'd13,
    4'd3, 4'd14, 4'd15, 4'd8, 4'd4, 4'd7, 4'd1, 4'd2
  };

  localparam logic [3:0] LED_MIX [0:3][0:3] = '{
    '{4'd4, 4'd1, 4'd2, 4'd2},
    '{4'd8, 4'd6, 4'd5, 4'd6},
    '{4'd11, 4'd14, 4'd10, 4'd9},
    '{4'd2, 4'd2, 4'd15, 4'd11}
  };

  localparam logic [5:0] LED_RC [0:ROUNDS_MAX-1] = '{
    6'h01, 6'h03, 6'h07, 6'h0F, 6'h1F, 6'h3E, 6'h3D, 6'h3B, 6'h37, 6'h2F,
    6'h1E, 6'h3C, 6'h39, 6'h33, 6'h27, 6'h0E, 6'h1D, 6'h3A, 6'h35, 6'h2B,
    6'h16, 6'h2C, 6'h18, 6'h30, 6'h21, 6'h02, 6'h05, 6'h0B, 6'h17, 6'h2E,
    6'h1C, 6'h38, 6'h31, 6'h23, 6'h06, 6'h0D, 6'h1B, 6'h36, 6'h2D, 6'h1A,
    6'h34, 6'h29, 6'h12, 6'h24, 6'h08, 6'h11, 6'h22, 6'h04
  };

  typedef logic [RK_ROWS-1:0][63:0] led_rk_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] key_size;
  } led_ctl_t;

  function automatic logic [3:0] gf16_mul(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] x;
    logic [3:0] acc;
    x = a;
    acc = 4'd0;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc = acc ^ x;
      x = x[3] ? ({x[2:0], 1'b0} ^ 4'h3) : {x[2:0], 1'b0};
    end
    return acc;
  endfunction

  function automatic logic [63:0] led_round_f(input logic [63:0] s, input logic [7:0] ks,
                                              input logic [5:0] rc);
    logic [3:0]  a [0:15];
    logic [3:0]  t [0:15];
    logic [3:0]  acc;
    logic [63:0] o;
    for (int c = 0; c < 16; c++) a[c] = s[4*(15-c) +: 4];
    a[0]  = a[0]  ^ ks[7:4];
    a[4]  = a[4]  ^ (4'd1 ^ ks[7:4]);
    a[8]  = a[8]  ^ (4'd2 ^ ks[3:0]);
    a[12] = a[12] ^ (4'd3 ^ ks[3:0]);
    a[1]  = a[1]  ^ {1'b0, rc[5:3]};
    a[9]  = a[9]  ^ {1'b0, rc[5:3]};
    a[5]  = a[5]  ^ {1'b0, rc[2:0]};
    a[13] = a[13] ^ {1'b0, rc[2:0]};
    for (int c = 0; c < 16; c++) a[c] = LED_SBOX[a[c]];
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        t[i*4+j] = a[i*4 + ((j+i) % 4)];
    o = '0;
    for (int j = 0; j < 4; j++)
      for (int i = 0; i < 4; i++) begin
        acc = 4'd0;
        for (int k = 0; k < 4; k++) acc = acc ^ gf16_mul(LED_MIX[i][k], t[k*4+j]);
        o[4*(15-(i*4+j)) +: 4] = acc;
      end
    return o;
  endfunction

endpackage
`default_nettype wire

/* src/led_key_sched.sv */
// Configuration registers and round key expansion, one key nibble per cycle.
`timescale 1ns / 1ps
`default_nettype none
module led_key_sched
  import led_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  output led_ctl_t         ctl,
  output led_rk_t          rk
);

  logic [7:0]       key_size_r;
  logic [63:0]      key_high_r;
  logic [63:0]      key_low_r;
  logic             active_r;
  logic [CNT_W-1:0] cnt_r;
  logic [4:0]       pos_r;
  led_rk_t          rk_r;

  logic [5:0]   n_raw;
  logic [5:0]   n_sat;
  logic [127:0] key_all;
  logic [3:0]   nib;
  logic [5:0]   pos_ext;

  assign n_raw   = key_size_r[7:2];
  assign n_sat   = (n_raw > KEY_NIB_MAX) ? KEY_NIB_MAX : n_raw;
  assign key_all = {key_high_r, key_low_r};
  assign pos_ext = {1'b0, pos_r};
  assign nib     = (n_sat == 6'd0) ? 4'd0 : key_all[{~pos_r, 2'b00} +: 4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_size_r <= KEY_SIZE_RST;
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_SIZE: key_size_r <= cfg_wdata[7:0];
        CFG_KEY_HIGH: key_high_r <= cfg_wdata;
        CFG_KEY_LOW:  key_low_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // restart expansion after reset and on every write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b1;
      cnt_r    <= '0;
      pos_r    <= '0;
    end else if (cfg_we) begin
      active_r <= 1'b1;
      cnt_r    <= '0;
      pos_r    <= '0;
    end else if (active_r) begin
      active_r <= (cnt_r != CNT_W'(RK_NIBBLES - 1));
      cnt_r    <= cnt_r + 1'b1;
      pos_r    <= (pos_ext == n_sat - 6'd1) ? 5'd0 : pos_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (active_r && !cfg_we) begin
      rk_r[cnt_r[CNT_W-1:4]][{~cnt_r[3:0], 2'b00} +: 4] <= nib;
    end
  end

  assign ctl.busy     = active_r;
  assign ctl.key_size = key_size_r;
  assign rk           = rk_r;

endmodule
`default_nettype wire

/* src/led_round.sv */
// One LED round stage with optional key add and pass-through.
`timescale 1ns / 1ps
`default_nettype none
module led_round
  import led_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        valid_i,
  input  wire logic [63:0] state_i,
  input  wire logic [7:0]  key_size_i,
  input  wire logic [5:0]  rc_i,
  input  wire logic        key_en_i,
  input  wire logic [63:0] rkey_i,
  input  wire logic        bypass_i,
  output logic             valid_o,
  output logic [63:0]      state_o
);

  logic        valid_r;
  logic [63:0] state_r;
  logic [63:0] state_nxt;
  logic [63:0] rnd;

  assign rnd       = led_round_f(state_i, key_size_i, rc_i);
  assign state_nxt = bypass_i ? state_i : (rnd ^ (key_en_i ? rkey_i : 64'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
  end

  assign valid_o = valid_r;
  assign state_o = state_r;

endmodule
`default_nettype wire

/* src/led_block_cipher_encrypt.sv */
// Top level: LED encryption with one round per pipeline stage.
// A word may enter every cycle while busy is low and then passes the input register and every round stage.
// Short keys (64 bits or less) pass unchanged through the last 16 stages, which still register the state.
// After reset and after each configuration write, busy stays high while the round keys
// are expanded one nibble per cycle.
// Synchronous active-low reset clears valid bits and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module led_block_cipher_encrypt
  import led_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] in_plaintext,
  output logic             out_valid,
  output logic [63:0]      out_ciphertext,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  led_ctl_t    ctl;
  led_rk_t     rk;
  logic        short_mode;
  logic        v     [0:ROUNDS_MAX];
  logic [63:0] st    [0:ROUNDS_MAX];
  logic        v0_r;
  logic [63:0] st0_r;

  led_key_sched u_key (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .rk        (rk)
  );

  assign busy       = ctl.busy;
  assign short_mode = (ctl.key_size <= KEY_SIZE_SHORT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !ctl.busy;
    end
  end

  always_ff @(posedge clk) begin
    st0_r <= in_plaintext ^ rk[0];
  end

  assign v[0]  = v0_r;
  assign st[0] = st0_r;

  for (genvar r = 0; r < ROUNDS_MAX; r++) begin : g_rnd
    localparam logic LATE = (r >= ROUNDS_MIN);
    localparam logic KADD = ((r % 4) == 3);
    led_round u_rnd (
      .clk        (clk),
      .rst_n      (rst_n),
      .valid_i    (v[r]),
      .state_i    (st[r]),
      .key_size_i (ctl.key_size),
      .rc_i       (LED_RC[r]),
      .key_en_i   (KADD),
      .rkey_i     (rk[r/4 + 1]),
      .bypass_i   (short_mode && LATE),
      .valid_o    (v[r+1]),
      .state_o    (st[r+1])
    );
  end

  assign out_valid      = v[ROUNDS_MAX];
  assign out_ciphertext = st[ROUNDS_MAX];

endmodule
`default_nettype wire

/* verif/led_cipher_checker.sv */
// Checker: predicts LED ciphertexts from accepted words and key writes, compares results.
`timescale 1ns / 1ps
module led_cipher_checker
  import led_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] in_plaintext,
  input  logic        out_valid,
  input  logic [63:0] out_ciphertext,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          pending_words
);

  logic [7:0]  key_size_q;
  logic [63:0] key_high_q;
  logic [63:0] key_low_q;
  logic [63:0] cipher_q [$];

  initial begin
    fail_count = 0;
    pending_words = 0;
    key_size_q = KEY_SIZE_RST;
    key_high_q = '0;
    key_low_q = '0;
  end

  function automatic logic [3:0] gf16_times(input logic [3:0] a, input logic [3:0] b);
    logic [3:0] p;
    logic [3:0] r;
    p = a;
    r = 4'd0;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) r = r ^ p;
      p = {p[2:0], 1'b0} ^ (p[3] ? 4'h3 : 4'h0);
    end
    return r;
  endfunction

  function automatic logic [3:0] key_nib(input int idx);
    if (idx < 16) return key_high_q[4*(15-idx) +: 4];
    return key_low_q[4*(31-idx) +: 4];
  endfunction

  function automatic logic [63:0] led_encrypt(input logic [63:0] pt);
    logic [3:0]  nibs [0:15];
    logic [3:0]  sh [0:15];
    logic [3:0]  acc;
    logic [5:0]  rc;
    logic [63:0] ct;
    int          nk;
    int          steps;
    nk = int'(key_size_q >> 2);
    if (nk > 32) nk = 32;
    steps = (key_size_q <= KEY_SIZE_SHORT) ? 8 : 12;
    for (int c = 0; c < 16; c++) nibs[c] = pt[4*(15-c) +: 4];
    for (int st = 0; st <= steps; st++) begin
      if (nk != 0) begin
        for (int c = 0; c < 16; c++) nibs[c] = nibs[c] ^ key_nib((c + 16*st) % nk);
      end
      if (st < steps) begin
        for (int j = 0; j < 4; j++) begin
          rc = LED_RC[st*4 + j];
          nibs[0]  = nibs[0]  ^ key_size_q[7:4];
          nibs[4]  = nibs[4]  ^ (4'd1 ^ key_size_q[7:4]);
          nibs[8]  = nibs[8]  ^ (4'd2 ^ key_size_q[3:0]);
          nibs[12] = nibs[12] ^ (4'd3 ^ key_size_q[3:0]);
          nibs[1]  = nibs[1]  ^ {1'b0, rc[5:3]};
          nibs[9]  = nibs[9]  ^ {1'b0, rc[5:3]};
          nibs[5]  = nibs[5]  ^ {1'b0, rc[2:0]};
          nibs[13] = nibs[13] ^ {1'b0, rc[2:0]};
          for (int c = 0; c < 16; c++) nibs[c] = LED_SBOX[nibs[c]];
          for (int row = 0; row < 4; row++)
            for (int col = 0; col < 4; col++)
              sh[row*4 + col] = nibs[row*4 + ((col + row) & 3)];
          for (int col = 0; col < 4; col++)
            for (int row = 0; row < 4; row++) begin
              acc = 4'd0;
              for (int k = 0; k < 4; k++) acc = acc ^ gf16_times(LED_MIX[row][k], sh[k*4 + col]);
              nibs[row*4 + col] = acc;
            end
        end
      end
    end
    for (int c = 0; c < 16; c++) ct[4*(15-c) +: 4] = nibs[c];
    return ct;
  endfunction

  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst_n) begin
      key_size_q = KEY_SIZE_RST;
      key_high_q = '0;
      key_low_q = '0;
      cipher_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_SIZE: key_size_q = cfg_wdata[7:0];
          CFG_KEY_HIGH: key_high_q = cfg_wdata;
          CFG_KEY_LOW:  key_low_q = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) cipher_q.push_back(led_encrypt(in_plaintext));
      if (out_valid) begin
        if (cipher_q.size() == 0) begin
          $error("ciphertext: expected none, got %h", out_ciphertext);
          fail_count++;
        end else begin
          want = cipher_q.pop_front();
          if (want !== out_ciphertext) begin
            $error("ciphertext: expected %h, got %h", want, out_ciphertext);
            fail_count++;
          end
        end
      end
    end
    pending_words = cipher_q.size();
  end

endmodule

/* verif/led_block_cipher_encrypt_tb.sv */
// Testbench top: drives plaintext words and key settings into the LED encryptor, gives the verdict.
`timescale 1ns / 1ps
module led_block_cipher_encrypt_tb;
  import led_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_plaintext;
  logic        out_valid;
  logic [63:0] out_ciphertext;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;
  int          fail_count;
  int          pending_words;
  bit          idle_on;

  logic [7:0] size_corners [0:10] = '{8'd0, 8'd1, 8'd3, 8'd4, 8'd63, 8'd64, 8'd65,
                                      8'd127, 8'd128, 8'd129, 8'd255};

  led_block_cipher_encrypt uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_plaintext(in_plaintext), .out_valid(out_valid), .out_ciphertext(out_ciphertext),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  led_cipher_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_plaintext(in_plaintext), .out_valid(out_valid), .out_ciphertext(out_ciphertext),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("led_block_cipher_encrypt_tb failed");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    do @(posedge clk); while (busy);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_key(input logic [7:0] ks, input logic [63:0] kh, input logic [63:0] kl);
    write_reg(CFG_KEY_SIZE, {56'd0, ks});
    write_reg(CFG_KEY_HIGH, kh);
    write_reg(CFG_KEY_LOW, kl);
  endtask

  task automatic send_block(input logic [63:0] pt);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_plaintext <= pt;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  task automatic directed_phase(input logic [7:0] ks, input logic [63:0] kh,
                                input logic [63:0] kl);
    load_key(ks, kh, kl);
    idle_on = 1'b1;
    send_block(64'd0);
    send_block('1);
    send_block({$urandom, $urandom});
    drain();
  endtask

  function automatic logic [63:0] pick_key();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [7:0] ks;
    rst_n = 1'b0;
    start = 1'b0;
    in_plaintext = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_KEY_SIZE;
    cfg_wdata = '0;
    idle_on = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset key: size 128, all-zero key
    send_block(64'd0);
    send_block('1);
    send_block(64'h0123456789abcdef);
    send_block(64'h5555555555555555);
    send_block(64'haaaaaaaaaaaaaaaa);
    drain();

    directed_phase(KEY_SIZE_SHORT, '1, '1);
    directed_phase(8'd0, {$urandom, $urandom}, {$urandom, $urandom});
    directed_phase(8'd255, '0, '1);
    directed_phase(8'd66, {$urandom, $urandom}, {$urandom, $urandom});
    directed_phase(8'd65, {$urandom, $urandom}, {$urandom, $urandom});

    for (int p = 0; p < 12; p++) begin
      if ($urandom_range(0, 2) == 0) ks = size_corners[4'($urandom_range(0, 10))];
      else ks = 8'($urandom_range(0, 255));
      load_key(ks, pick_key(), pick_key());
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (140) send_block({$urandom, $urandom});
      drain();
    end

    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("led_block_cipher_encrypt_tb passed");
    end else begin
      $display("led_block_cipher_encrypt_tb failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/led_pkg.sv
src/led_key_sched.sv
src/led_round.sv
src/led_block_cipher_encrypt.sv
verif/led_cipher_checker.sv
verif/led_block_cipher_encrypt_tb.sv
